// ----- design/dlbd_pkg.sv -----
// Shared constants and types for the definite-length block sample deframer.
`timescale 1ns / 1ps
`default_nettype none

package dlbd_pkg;

  // Default width of the payload length and byte counters.
  localparam int LenBitsDefault = 30;

  // Characters of the block header.
  localparam logic [7:0] HashChar  = 8'h23;
  localparam logic [7:0] ZeroChar  = 8'h30;
  localparam logic [7:0] MaxDigit  = 8'd9;

  // Result event codes.
  localparam logic [2:0] EvSample  = 3'd0;
  localparam logic [2:0] EvBegin   = 3'd1;
  localparam logic [2:0] EvEnd     = 3'd2;
  localparam logic [2:0] EvStopped = 3'd3;
  localparam logic [2:0] EvBadLen  = 3'd4;

  // Up to three results caused by one received byte. Only the first one can
  // be a sample, so one raw value serves the whole group.
  typedef struct packed {
    logic [1:0]  cnt;
    logic [2:0]  ev0;
    logic [2:0]  ev1;
    logic [2:0]  ev2;
    logic [15:0] raw;
  } bundle_t;

endpackage

`default_nettype wire

// ----- design/dlbd_core.sv -----
// Parser state and per-byte decode of the deframer.
`timescale 1ns / 1ps
`default_nettype none

module dlbd_core
  import dlbd_pkg::*;
#(
  parameter int LEN_BITS = LenBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        take,
  input  wire logic [7:0]  rx_byte,
  input  wire logic [15:0] frame_limit,
  output bundle_t          bundle
);

  localparam logic [2:0] PhHunt  = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhLen   = 3'd2;
  localparam logic [2:0] PhData  = 3'd3;
  localparam logic [2:0] PhStop  = 3'd4;

  localparam logic [LEN_BITS-1:0] LenMax = '1;

  logic [2:0]          phase, phase_next;
  logic [3:0]          digits_left, digits_left_next;
  logic [LEN_BITS-1:0] length_accum, length_accum_next;
  logic [LEN_BITS-1:0] bytes_taken, bytes_taken_next;
  logic [7:0]          high_byte, high_byte_next;
  logic                have_high, have_high_next;
  logic [15:0]         frames_done, frames_done_next;

  logic [7:0]          digit;
  logic                is_digit;
  logic [LEN_BITS+3:0] len_prod;
  logic [LEN_BITS-1:0] len_sat;
  logic [LEN_BITS:0]   bytes_sum;
  logic [LEN_BITS-1:0] bytes_sat;
  logic [15:0]         frames_inc;

  assign digit    = rx_byte - ZeroChar;
  assign is_digit = (digit <= MaxDigit);

  // length * 10 + digit, as shift-and-add, saturated to the counter width.
  assign len_prod = {1'b0, length_accum, 3'b000} + {3'b000, length_accum, 1'b0}
                  + {{(LEN_BITS - 4){1'b0}}, digit};
  assign len_sat  = (|len_prod[LEN_BITS+3:LEN_BITS]) ? LenMax : len_prod[LEN_BITS-1:0];

  assign bytes_sum  = {1'b0, bytes_taken} + {{(LEN_BITS - 1){1'b0}}, 2'b10};
  assign bytes_sat  = bytes_sum[LEN_BITS] ? LenMax : bytes_sum[LEN_BITS-1:0];
  assign frames_inc = (frames_done == 16'hFFFF) ? frames_done : frames_done + 16'd1;

  always_comb begin
    phase_next        = phase;
    digits_left_next  = digits_left;
    length_accum_next = length_accum;
    bytes_taken_next  = bytes_taken;
    high_byte_next    = high_byte;
    have_high_next    = have_high;
    frames_done_next  = frames_done;
    bundle            = '0;

    case (phase)
      PhHunt: begin
        if (rx_byte == HashChar) begin
          phase_next = PhCount;
        end
      end
      PhCount: begin
        if (!is_digit) begin
          bundle.cnt = 2'd1;
          bundle.ev0 = EvBadLen;
          phase_next = PhHunt;
        end else if (digit == 8'd0) begin
          phase_next = PhHunt;
        end else begin
          digits_left_next  = digit[3:0];
          length_accum_next = '0;
          phase_next        = PhLen;
        end
      end
      PhLen: begin
        if (!is_digit) begin
          bundle.cnt       = 2'd1;
          bundle.ev0       = EvBadLen;
          phase_next       = PhHunt;
          digits_left_next = 4'd0;
        end else begin
          length_accum_next = len_sat;
          digits_left_next  = digits_left - 4'd1;
          if (digits_left == 4'd1) begin
            if (len_sat == '0) begin
              phase_next = PhHunt;
            end else begin
              bundle.cnt       = 2'd1;
              bundle.ev0       = EvBegin;
              bytes_taken_next = '0;
              have_high_next   = 1'b0;
              phase_next       = PhData;
            end
          end
        end
      end
      PhData: begin
        if (!have_high) begin
          high_byte_next = rx_byte;
          have_high_next = 1'b1;
        end else begin
          bundle.cnt       = 2'd1;
          bundle.ev0       = EvSample;
          bundle.raw       = {high_byte, rx_byte};
          have_high_next   = 1'b0;
          bytes_taken_next = bytes_sat;
          if (bytes_sat >= length_accum) begin
            bundle.cnt       = 2'd2;
            bundle.ev1       = EvEnd;
            bytes_taken_next = '0;
            frames_done_next = frames_inc;
            if (frames_inc >= frame_limit) begin
              bundle.cnt = 2'd3;
              bundle.ev2 = EvStopped;
              phase_next = PhStop;
            end else begin
              phase_next = PhHunt;
            end
          end
        end
      end
      default: begin
        phase_next = PhStop;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PhHunt;
      digits_left  <= 4'd0;
      length_accum <= '0;
      bytes_taken  <= '0;
      high_byte    <= 8'd0;
      have_high    <= 1'b0;
      frames_done  <= 16'd0;
    end else if (take) begin
      phase        <= phase_next;
      digits_left  <= digits_left_next;
      length_accum <= length_accum_next;
      bytes_taken  <= bytes_taken_next;
      high_byte    <= high_byte_next;
      have_high    <= have_high_next;
      frames_done  <= frames_done_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/definite_length_block_sample_deframer.sv -----
// Top level of the definite-length block sample deframer.
`timescale 1ns / 1ps
`default_nettype none

// The deframer takes one received byte per input transaction. It skips bytes
// until a '#' arrives, reads a digit count and then that many decimal length
// digits, and pairs the payload bytes big-endian into 16-bit samples. Every
// sample comes out both raw and as (raw - 32768) * 5, a signed 19-bit integer.
// Frame begin, frame end, stopped and bad length are reported as events on the
// same result channel, and is_last marks the final result caused by a byte.
// A byte is decoded in the cycle it is accepted; its results (zero to three)
// go to a small pending register and leave one per output transaction through
// an output register. With a ready consumer the block takes one byte every
// cycle as long as each byte causes at most one result; a byte that causes two
// or three results (a sample closing a frame) holds the input while the
// pending register drains. The frame_limit register is written through the
// configuration channel and is checked at each frame end; after the limit is
// reached every later byte is accepted and dropped until reset.
module definite_length_block_sample_deframer
  import dlbd_pkg::*;
#(
  parameter int LEN_BITS = LenBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         rx_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              event_res,
  output logic [15:0]             raw_sample,
  output logic signed [18:0]      scaled_sample,
  output logic                    is_last,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [15:0]        cfg_data
);

  logic [15:0] frame_limit;
  bundle_t     bundle;
  logic        take;
  logic        out_free;
  logic        move;

  // Results of the last accepted byte that have not yet gone to the output
  // register, oldest first.
  logic [1:0]  pend_cnt;
  logic [2:0]  pend_ev [0:2];
  logic [15:0] pend_raw;

  logic signed [16:0] centered;
  logic signed [18:0] scaled_next;
  logic               pend_is_sample;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;
  assign move      = (pend_cnt != 2'd0) && out_free;
  // A new byte may enter once the pending register is empty, or will be in
  // this same cycle.
  assign in_ready  = (pend_cnt == 2'd0) || ((pend_cnt == 2'd1) && out_free);
  assign take      = in_valid && in_ready;

  dlbd_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .rx_byte     (rx_byte),
    .frame_limit (frame_limit),
    .bundle      (bundle)
  );

  // raw - 32768 is the raw word with its top bit flipped, read as signed;
  // times five is a shift by two plus the value itself.
  assign pend_is_sample = (pend_ev[0] == EvSample);
  assign centered       = {~pend_raw[15], ~pend_raw[15], pend_raw[14:0]};
  assign scaled_next    = {centered, 2'b00} + {{2{centered[16]}}, centered};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= 16'd1;
      pend_cnt    <= 2'd0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        frame_limit <= cfg_data;
      end
      if (take) begin
        pend_cnt <= bundle.cnt;
      end else if (move) begin
        pend_cnt <= pend_cnt - 2'd1;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pend_ev[0] <= bundle.ev0;
      pend_ev[1] <= bundle.ev1;
      pend_ev[2] <= bundle.ev2;
      pend_raw   <= bundle.raw;
    end else if (move) begin
      pend_ev[0] <= pend_ev[1];
      pend_ev[1] <= pend_ev[2];
    end
    if (move) begin
      event_res     <= pend_ev[0];
      is_last       <= (pend_cnt == 2'd1);
      raw_sample    <= pend_is_sample ? pend_raw : 16'd0;
      scaled_sample <= pend_is_sample ? scaled_next : 19'sd0;
    end
  end

endmodule

`default_nettype wire

// ----- design/dlbd_checker.sv -----
// Port-level checks for the deframer and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dlbd_checker
  import dlbd_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic [2:0]         event_res,
  input wire logic [15:0]        raw_sample,
  input wire logic signed [18:0] scaled_sample,
  input wire logic               is_last
);

  // A stalled result transaction keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_res) && $stable(raw_sample)
      && $stable(scaled_sample) && $stable(is_last))
    else $error("result changed while stalled");

  // Events other than samples carry zero sample fields.
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res != EvSample |-> raw_sample == 16'd0 && scaled_sample == 19'sd0)
    else $error("non-sample event carries sample data");

  // The scaled value follows the raw one.
  a_scale: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_res == EvSample
      |-> scaled_sample == 19'((int'(raw_sample) - 32768) * 5))
    else $error("scaled sample does not match raw sample");

  // Stopped and bad length always close the results of their byte.
  a_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (event_res == EvStopped || event_res == EvBadLen) |-> is_last)
    else $error("terminal event not marked last");

endmodule

bind definite_length_block_sample_deframer dlbd_checker u_dlbd_checker (.*);

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the definite-length block sample deframer.
`timescale 1ns / 1ps

// The testbench streams received bytes into the deframer and checks every
// result transaction against its own model of the block header parser. The
// model runs when a byte transaction is accepted and queues the events that
// the byte must cause, in order. The monitor pops one queued event for each
// output transaction and compares all four fields.
//
// The run has these parts:
//   - A directed part: a bad digit count, a zero digit count, a zero length,
//     a bad length digit, an even frame with the extreme sample values and an
//     odd-length frame.
//   - Three random parts, each with different idle rates on the input and
//     output channels.
//   - A closing part that lowers frame_limit below the number of frames
//     already done. The next frame end must report the stop, and every
//     later byte must be dropped.
module tb_top;
  import dlbd_pkg::*;

  localparam int HalfPeriod   = 5;
  localparam int ResetCycles  = 4;
  // The block decodes a byte as it takes it and puts its results out through a
  // short pending register, so SettleCycles covers any work in flight.
  localparam int SettleCycles = 8;
  localparam int PhaseBytes   = 55;
  localparam longint unsigned LenMax = (64'd1 << LenBitsDefault) - 1;

  // Parser phases of the model.
  typedef enum logic [2:0] {
    SeekHash,
    ReadCount,
    ReadLength,
    TakePayload,
    Halted
  } parse_phase_e;

  // One result transaction as the deframer should put it out.
  typedef struct packed {
    logic [2:0]         ev;
    logic [15:0]        raw;
    logic signed [18:0] scaled;
    logic               last;
  } deframe_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         event_res;
  logic [15:0]        raw_sample;
  logic signed [18:0] scaled_sample;
  logic               is_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = 16'h0000;

  definite_length_block_sample_deframer u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .event_res     (event_res),
    .raw_sample    (raw_sample),
    .scaled_sample (scaled_sample),
    .is_last       (is_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #HalfPeriod clk = ~clk;

  // Bytes still to be sent, and the results that accepted bytes still owe.
  logic [7:0]      tx_bytes[$];
  deframe_result_t pending_events[$];

  // Idle rates in percent, changed between the parts of the run.
  int send_idle_pct = 34;
  int recv_idle_pct = 64;

  // Handshake flags, set at the rising edge and read by the falling-edge
  // driver and by the register write task.
  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;

  int error_count    = 0;
  int bytes_accepted = 0;
  int fed_items      = 0;
  int tally [0:4]    = '{0, 0, 0, 0, 0};

  // Model state of the deframer.
  parse_phase_e    parse_phase  = SeekHash;
  logic [3:0]      digits_left  = 4'd0;
  longint unsigned length_val   = 0;
  longint unsigned bytes_paired = 0;
  logic [7:0]      high_byte_q  = 8'h00;
  logic            high_pending = 1'b0;
  logic [15:0]     frames_seen  = 16'd0;
  logic [15:0]     limit_frames = 16'd1;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic deframe_result_t event_result(input logic [2:0] ev);
    deframe_result_t r;
    r.ev     = ev;
    r.raw    = 16'd0;
    r.scaled = 19'sd0;
    r.last   = 1'b0;
    return r;
  endfunction

  // Advance the model by one accepted byte and queue the results it causes.
  function automatic void deframe_byte(input logic [7:0] b);
    logic [7:0]      digit;
    logic [15:0]     word;
    int              centered;
    deframe_result_t batch [3];
    int              n;
    n = 0;
    digit = b - ZeroChar;
    case (parse_phase)
      SeekHash: begin
        if (b == HashChar) parse_phase = ReadCount;
      end
      ReadCount: begin
        if (digit > MaxDigit) begin
          batch[n] = event_result(EvBadLen);
          n++;
          parse_phase = SeekHash;
        end else if (digit == 8'd0) begin
          parse_phase = SeekHash;
        end else begin
          digits_left = digit[3:0];
          length_val  = 0;
          parse_phase = ReadLength;
        end
      end
      ReadLength: begin
        if (digit > MaxDigit) begin
          batch[n] = event_result(EvBadLen);
          n++;
          parse_phase = SeekHash;
          digits_left = 4'd0;
        end else begin
          length_val = length_val * 10 + digit;
          if (length_val > LenMax) length_val = LenMax;
          digits_left = digits_left - 4'd1;
          if (digits_left == 4'd0) begin
            if (length_val == 0) begin
              parse_phase = SeekHash;
            end else begin
              batch[n] = event_result(EvBegin);
              n++;
              bytes_paired = 0;
              high_pending = 1'b0;
              parse_phase  = TakePayload;
            end
          end
        end
      end
      TakePayload: begin
        if (!high_pending) begin
          high_byte_q  = b;
          high_pending = 1'b1;
        end else begin
          // The first byte of a pair is the high byte of the sample.
          word     = {high_byte_q, b};
          centered = (int'(word) - 32768) * 5;
          batch[n] = event_result(EvSample);
          batch[n].raw    = word;
          batch[n].scaled = centered[18:0];
          n++;
          high_pending = 1'b0;
          bytes_paired += 2;
          if (bytes_paired > LenMax) bytes_paired = LenMax;
          // An odd length ends on the sample that carries the padding byte.
          if (bytes_paired >= length_val) begin
            batch[n] = event_result(EvEnd);
            n++;
            bytes_paired = 0;
            if (frames_seen != 16'hFFFF) frames_seen++;
            // The limit is looked at only here, so a limit already below the
            // frame count stops the block at this frame end.
            if (frames_seen >= limit_frames) begin
              batch[n] = event_result(EvStopped);
              n++;
              parse_phase = Halted;
            end else begin
              parse_phase = SeekHash;
            end
          end
        end
      end
      default: parse_phase = Halted;
    endcase
    if (n > 0) batch[n - 1].last = 1'b1;
    for (int k = 0; k < n; k++) pending_events.push_back(batch[k]);
  endfunction

  // Driver: byte and output-ready changes happen at the falling edge. A byte
  // stays on the port until the rising edge at which it is taken.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || in_taken) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_byte  <= tx_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: sample every handshake at the rising edge, check results and
  // feed accepted bytes and register writes to the model.
  always @(posedge clk) begin : monitor
    deframe_result_t want;
    in_taken  <= !rst && in_valid && in_ready;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result, event %0d raw %h",
                                    event_res, raw_sample));
        end else begin
          want = pending_events.pop_front();
          tally[want.ev]++;
          if (event_res !== want.ev)
            report_mismatch($sformatf("event_res got %0d, want %0d",
                                      event_res, want.ev));
          if (raw_sample !== want.raw)
            report_mismatch($sformatf("raw_sample got %h, want %h",
                                      raw_sample, want.raw));
          if (scaled_sample !== want.scaled)
            report_mismatch($sformatf("scaled_sample got %0d, want %0d",
                                      scaled_sample, want.scaled));
          if (is_last !== want.last)
            report_mismatch($sformatf("is_last got %b, want %b (event %0d)",
                                      is_last, want.last, want.ev));
        end
      end
      if (in_valid && in_ready) begin
        bytes_accepted++;
        deframe_byte(rx_byte);
      end
      if (cfg_valid && cfg_ready) begin
        limit_frames = cfg_data;
      end
    end
  end

  // Queue a byte that the block must act on.
  function automatic void feed(input logic [7:0] b);
    tx_bytes.push_back(b);
    fed_items++;
  endfunction

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic logic [7:0] non_digit();
    logic [7:0] junk;
    do junk = 8'($urandom_range(255));
    while (junk >= ZeroChar && junk <= ZeroChar + MaxDigit);
    return junk;
  endfunction

  // A complete frame: header with ndig length digits (leading zeros where
  // the length needs fewer) and a random payload, padded to an even count.
  task automatic queue_frame(input int len, input int ndig);
    int scale;
    feed(HashChar);
    feed(8'(ZeroChar + ndig));
    scale = 1;
    for (int k = 1; k < ndig; k++) scale *= 10;
    for (int k = 0; k < ndig; k++) begin
      feed(8'(ZeroChar + (len / scale) % 10));
      scale /= 10;
    end
    for (int k = 0; k < len + len % 2; k++) feed(payload_byte());
  endtask

  // Mostly short frames, a few longer ones, some with surplus length digits.
  task automatic queue_random_frame();
    int len;
    int ndig;
    if ($urandom_range(9) == 0) len = $urandom_range(13, 40);
    else len = $urandom_range(1, 12);
    ndig = (len < 10) ? 1 : 2;
    if ($urandom_range(3) == 0) ndig += $urandom_range(9 - ndig);
    queue_frame(len, ndig);
  endtask

  // Headers that go wrong at some point and send the block back to hunting.
  task automatic queue_broken_header();
    int count;
    feed(HashChar);
    case ($urandom_range(3))
      0: feed(non_digit());
      1: feed(ZeroChar);
      2: begin
        count = $urandom_range(1, 9);
        feed(8'(ZeroChar + count));
        repeat ($urandom_range(count - 1)) feed(8'(ZeroChar + $urandom_range(9)));
        feed(non_digit());
      end
      default: begin
        count = $urandom_range(1, 9);
        feed(8'(ZeroChar + count));
        repeat (count) feed(ZeroChar);
      end
    endcase
  endtask

  // Line noise while hunting; a hash mark here would start a stray header.
  task automatic queue_noise();
    logic [7:0] junk;
    repeat ($urandom_range(1, 4)) begin
      junk = 8'($urandom_range(255));
      if (junk == HashChar) junk = ~junk;
      tx_bytes.push_back(junk);
    end
  endtask

  // Hold the sender until every byte is in and every result has come out.
  task automatic drain();
    while (tx_bytes.size() != 0 || in_valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_frame_limit(input logic [15:0] value);
    @(negedge clk);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_part(input int target);
    int  first;
    int  pick;
    logic paused;
    first  = fed_items;
    paused = 1'b0;
    while (fed_items - first < target) begin
      pick = $urandom_range(99);
      if (pick < 70) queue_random_frame();
      else if (pick < 85) queue_broken_header();
      else queue_noise();
      // Once per part, halfway through, the sender waits for all results.
      if (!paused && fed_items - first >= target / 2) begin
        drain();
        paused = 1'b1;
      end
    end
    drain();
  endtask

  initial begin
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The reset limit of one frame would stop the block at the first frame end.
    set_frame_limit(16'hFFFF);

    // Directed part. Noise bytes at both ends of the byte range come first.
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFF);
    // Digit count just below the digit range.
    feed(HashChar); feed("/");
    // Digit count of zero.
    feed(HashChar); feed("0");
    // Two length digits that give a zero length.
    feed(HashChar); feed("2"); feed("0"); feed("0");
    // Length digit just above the digit range.
    feed(HashChar); feed("2"); feed("1"); feed(":");
    // Even frame carrying the lowest and highest sample.
    feed(HashChar); feed("1"); feed("4");
    feed(8'h00); feed(8'h00); feed(8'hFF); feed(8'hFF);
    // Odd frame: the midscale sample and one that closes with a pad byte.
    feed(HashChar); feed("1"); feed("3");
    feed(8'h80); feed(8'h00); feed(8'h7F); feed(8'hFF);
    drain();

    run_random_part(PhaseBytes);

    set_frame_limit(16'($urandom_range(1000, 65534)));
    send_idle_pct = 64;
    recv_idle_pct = 34;
    run_random_part(PhaseBytes);

    set_frame_limit(16'($urandom_range(1000, 65534)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_part(PhaseBytes);

    // A limit below the frames already done stops the block at the next
    // frame end; the sample, the frame end and the stop come from the same byte.
    set_frame_limit(16'd1);
    queue_frame(2, 1);
    // Everything after the stop is dropped, whole frames included.
    queue_noise();
    queue_frame(4, 1);
    queue_broken_header();
    drain();

    $display("Run covered %0d accepted bytes over %0d frames at three idle settings",
             bytes_accepted, frames_seen);
    $display("Checked %0d samples, %0d begins, %0d ends, %0d bad lengths, %0d stops",
             tally[EvSample], tally[EvBegin], tally[EvEnd], tally[EvBadLen],
             tally[EvStopped]);
    if (error_count == 0) begin
      $display("definite_length_block_sample_deframer regression: pass");
    end else begin
      $display("definite_length_block_sample_deframer regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #3_000_000;
    $display("Timeout with %0d results still expected", pending_events.size());
    $display("definite_length_block_sample_deframer regression: fail");
    $finish;
  end

endmodule

// ----- files.f -----
design/dlbd_pkg.sv
design/dlbd_core.sv
design/definite_length_block_sample_deframer.sv
design/dlbd_checker.sv
tb/tb_top.sv
